>>> rtl/gdpc_pkg.sv
// Package for the gapped DNA pattern counter: defaults, register codes, config type.
`timescale 1ns / 1ps

package gdpc_pkg;

  localparam int DEF_MAX_PATTERN = 32;
  localparam int DEF_MAX_GAP     = 3;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int SYMBOL_W    = 8;
  localparam int COUNT_W     = 8;
  localparam int TOTAL_W     = 32;
  localparam int LENGTH_W    = 6;
  localparam int GAP_CFG_W   = 2;

  // ASCII codes of the four bases
  localparam logic [SYMBOL_W-1:0] ASCII_A = 8'd65;
  localparam logic [SYMBOL_W-1:0] ASCII_C = 8'd67;
  localparam logic [SYMBOL_W-1:0] ASCII_G = 8'd71;
  localparam logic [SYMBOL_W-1:0] ASCII_T = 8'd84;

  typedef enum logic [1:0] {
    BASE_A = 2'd0,
    BASE_C = 2'd1,
    BASE_G = 2'd2,
    BASE_T = 2'd3
  } base_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_CODES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_MAX_GAP        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_codes;
    logic [LENGTH_W-1:0]   pattern_length;
    logic [GAP_CFG_W-1:0]  max_gap;
  } cfg_t;

endpackage

>>> rtl/gdpc_step.sv
// Next-state logic for the walker counts on one text byte, plus the match increment.
`timescale 1ns / 1ps

module gdpc_step #(
  parameter int MAX_PATTERN = gdpc_pkg::DEF_MAX_PATTERN,
  parameter int MAX_GAP     = gdpc_pkg::DEF_MAX_GAP
) (
  input  gdpc_pkg::cfg_t                   cfg,
  input  logic [gdpc_pkg::SYMBOL_W-1:0]    symbol,
  input  logic [gdpc_pkg::COUNT_W-1:0]     cnt_cur [MAX_PATTERN][MAX_GAP+1],
  output logic [gdpc_pkg::COUNT_W-1:0]     cnt_nxt [MAX_PATTERN][MAX_GAP+1],
  output logic [gdpc_pkg::COUNT_W+$clog2(MAX_GAP+1)-1:0] match_inc
);

  localparam int GW = (MAX_GAP > 0) ? $clog2(MAX_GAP + 1) : 1;
  localparam int SW = gdpc_pkg::COUNT_W + $clog2(MAX_GAP + 1);
  localparam int LW = gdpc_pkg::LENGTH_W;

  logic                              base_ok;
  gdpc_pkg::base_t                   base;
  logic [LW-1:0]                     len_eff;
  logic [GW-1:0]                     gap_eff;
  logic [SW-1:0]                     row_sum [MAX_PATTERN];
  logic                              row_hit [MAX_PATTERN];

  // Decode the text byte
  always_comb begin
    base_ok = 1'b1;
    base    = gdpc_pkg::BASE_A;
    case (symbol)
      gdpc_pkg::ASCII_A: base = gdpc_pkg::BASE_A;
      gdpc_pkg::ASCII_C: base = gdpc_pkg::BASE_C;
      gdpc_pkg::ASCII_G: base = gdpc_pkg::BASE_G;
      gdpc_pkg::ASCII_T: base = gdpc_pkg::BASE_T;
      default:           base_ok = 1'b0;
    endcase
  end

  // Clamp the configured length and gap into the supported range
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LW'(1);
    end else if (cfg.pattern_length > LW'(MAX_PATTERN)) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = cfg.pattern_length;
    end
    if ({2'b00, cfg.max_gap} > 4'(MAX_GAP)) begin
      gap_eff = GW'(MAX_GAP);
    end else begin
      gap_eff = GW'(cfg.max_gap);
    end
  end

  // Per matched-symbol row: total walkers waiting on that symbol, and whether it arrived
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      row_sum[i] = '0;
      for (int g = 0; g <= MAX_GAP; g++) begin
        if (GW'(g) <= gap_eff) begin
          if (i == 0) begin
            // one fresh walker enters the start state on every byte
            if (g == 0) row_sum[i] = SW'(1);
          end else begin
            row_sum[i] = row_sum[i] + SW'(cnt_cur[i][g]);
          end
        end
      end
      row_hit[i] = base_ok && (LW'(i) < len_eff) &&
                   (cfg.pattern_codes[2*i +: 2] == base);
    end
  end

  always_comb begin
    match_inc = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      for (int g = 0; g <= MAX_GAP; g++) begin
        cnt_nxt[i][g] = '0;
      end
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (row_hit[i] && (LW'(i) + LW'(1) == len_eff)) match_inc = row_sum[i];
    end
    for (int i = 1; i < MAX_PATTERN; i++) begin
      // advance walkers that saw their awaited symbol
      if (row_hit[i-1] && (LW'(i) < len_eff)) begin
        if (row_sum[i-1] > SW'(255)) cnt_nxt[i][0] = 8'd255;
        else cnt_nxt[i][0] = row_sum[i-1][gdpc_pkg::COUNT_W-1:0];
      end
      // skip a non-matching base while gap budget remains
      if (base_ok && !row_hit[i] && (LW'(i) < len_eff)) begin
        for (int g = 0; g < MAX_GAP; g++) begin
          if (GW'(g) < gap_eff) cnt_nxt[i][g+1] = cnt_cur[i][g];
        end
      end
    end
  end

endmodule

>>> rtl/gapped_dna_pattern_counter_top.sv
// Top level of the gapped DNA pattern counter: handshakes, state and config registers.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per request in
//   in_symbol, with in_last_symbol marking the final byte of a sequence.
//   Output channel (out_valid / out_stall) carries one request per sequence:
//   out_match_count, the saturating number of start positions whose gapped
//   walk reached the last pattern symbol.
//   Config port (cfg_we, cfg_index, cfg_wdata) writes pattern_codes (0),
//   pattern_length (1) and max_gap (2); any known write clears the sequence.
//   Throughput: one byte per cycle while in_stall is low; all walker counts
//   update in parallel through the input register and the state update logic.
//   Result path: the count appears on out_valid after the last byte is
//   accepted, passing first through the input register and then the result
//   register (a last byte may wait in the input register on a stall).
//   Stall: ordinary bytes keep flowing while a result waits; a last byte
//   holds in the input register, and in_stall rises, only while the result
//   register is full and stalled.
//   Reset (rst_n low, synchronous) clears all counts, empties both stages and
//   restores pattern_codes 0, pattern_length 1, max_gap 0.

module gapped_dna_pattern_counter_top #(
  parameter int MAX_PATTERN = gdpc_pkg::DEF_MAX_PATTERN,
  parameter int MAX_GAP     = gdpc_pkg::DEF_MAX_GAP
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gdpc_pkg::SYMBOL_W-1:0]       in_symbol,
  input  logic                                in_last_symbol,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gdpc_pkg::TOTAL_W-1:0]        out_match_count,
  input  logic                                cfg_we,
  input  logic [gdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SW = gdpc_pkg::COUNT_W + $clog2(MAX_GAP + 1);
  localparam int TW = gdpc_pkg::TOTAL_W;

  gdpc_pkg::cfg_t                    cfg_r, cfg_nxt;
  logic                              cfg_clear;
  logic                              s1_valid_r;
  logic [gdpc_pkg::SYMBOL_W-1:0]     s1_symbol_r;
  logic                              s1_last_r;
  logic                              s1_adv;
  logic                              in_accept;
  logic                              out_free;
  logic [gdpc_pkg::COUNT_W-1:0]      cnt_r   [MAX_PATTERN][MAX_GAP+1];
  logic [gdpc_pkg::COUNT_W-1:0]      cnt_nxt [MAX_PATTERN][MAX_GAP+1];
  logic [SW-1:0]                     match_inc;
  logic [TW-1:0]                     total_r;
  logic [TW:0]                       total_sum;
  logic [TW-1:0]                     total_new;
  logic                              out_valid_r;
  logic [TW-1:0]                     out_match_count_r;

  // Config register writes
  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      case (gdpc_pkg::cfg_reg_t'(cfg_index))
        gdpc_pkg::REG_PATTERN_CODES: begin
          cfg_nxt.pattern_codes = cfg_wdata;
          cfg_clear = 1'b1;
        end
        gdpc_pkg::REG_PATTERN_LENGTH: begin
          cfg_nxt.pattern_length = cfg_wdata[gdpc_pkg::LENGTH_W-1:0];
          cfg_clear = 1'b1;
        end
        gdpc_pkg::REG_MAX_GAP: begin
          cfg_nxt.max_gap = cfg_wdata[gdpc_pkg::GAP_CFG_W-1:0];
          cfg_clear = 1'b1;
        end
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_codes  <= '0;
      cfg_r.pattern_length <= gdpc_pkg::LENGTH_W'(1);
      cfg_r.max_gap        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: a last byte needs room in the result register to advance
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_symbol_r <= in_symbol;
      s1_last_r   <= in_last_symbol;
    end
  end

  gdpc_step #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_GAP     (MAX_GAP)
  ) u_step (
    .cfg       (cfg_r),
    .symbol    (s1_symbol_r),
    .cnt_cur   (cnt_r),
    .cnt_nxt   (cnt_nxt),
    .match_inc (match_inc)
  );

  // Saturating running total
  assign total_sum = {1'b0, total_r} + (TW + 1)'(match_inc);
  assign total_new = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      total_r <= '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        for (int g = 0; g <= MAX_GAP; g++) begin
          cnt_r[i][g] <= '0;
        end
      end
    end else if (s1_adv) begin
      // drop all walkers at the end of a sequence
      total_r <= s1_last_r ? '0 : total_new;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        for (int g = 0; g <= MAX_GAP; g++) begin
          cnt_r[i][g] <= s1_last_r ? '0 : cnt_nxt[i][g];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) out_match_count_r <= total_new;
  end

  assign out_valid       = out_valid_r;
  assign out_match_count = out_match_count_r;

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result raised without a last byte leaving the input register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled while the result path was free");

  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (total_r == '0))
    else $error("running total not cleared after the last byte");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_match_count_r)))
    else $error("stalled result lost or changed");
`endif

endmodule
